// ===== src/esc_pkg.sv =====
`default_nettype none
package esc_pkg;

  localparam int unsigned SecsW   = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  localparam int unsigned SecsPerDay     = 86400;
  localparam int unsigned SecsPerHour    = 3600;
  localparam int unsigned SecsPerMin     = 60;
  localparam int unsigned FirstYear      = 1970;
  localparam int unsigned DaysLeapYear   = 366;
  localparam int unsigned DaysCommonYear = 365;

  typedef logic [SecsW-1:0]   secs_t;
  typedef logic [YearW-1:0]   year_t;
  typedef logic [MonthW-1:0]  month_t;
  typedef logic [DayW-1:0]    day_t;
  typedef logic [HourW-1:0]   hour_t;
  typedef logic [MinuteW-1:0] minute_t;
  typedef logic [SecondW-1:0] second_t;

  // days in a month, february widened when the year is a leap year
  function automatic logic [4:0] month_len(input month_t m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== src/esc_in_if.sv =====
`default_nettype none
interface esc_in_if;
  import esc_pkg::*;

  logic  valid;
  logic  ready;
  secs_t epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface
`default_nettype wire

// ===== src/esc_out_if.sv =====
`default_nettype none
interface esc_out_if;
  import esc_pkg::*;

  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  day_t    day;
  hour_t   hour;
  minute_t minute;
  second_t second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

// ===== src/epoch_seconds_to_calendar_unit.sv =====
`default_nettype none
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day, hour, minute and second, one result word per input word.
// Every year divisible by four counts as a leap year (2100 included). The
// whole conversion runs on one shared 18-bit subtract/compare unit under a
// small sequencer: 32 restoring steps split off the day count and the
// seconds of the day, 5 steps give the hour, 6 the minute, then one step per
// year tested from 1970 (up to 137) and one per month tested (up to 12).
// The year walk dominates the conversion time. The input is ready only while
// the sequencer is idle; a finished word sits in the output register until
// taken, and the next input is accepted while it waits there.
module epoch_seconds_to_calendar_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  esc_in_if.sink     in_s,
  esc_out_if.source  out_m
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  localparam int unsigned OpW = 18;

  state_t        st_r, st_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  secs_t         acc_r, acc_nxt;   // dividend, then day count (0-based)
  logic [16:0]   rem_r, rem_nxt;   // seconds of the day, then of hour, minute
  hour_t         hour_r, hour_nxt;
  minute_t       min_r, min_nxt;
  year_t         year_r, year_nxt;
  month_t        month_r, month_nxt;

  logic          out_valid_r, out_valid_nxt;
  year_t         out_year_r, out_year_nxt;
  month_t        out_month_r, out_month_nxt;
  day_t          out_day_r, out_day_nxt;
  hour_t         out_hour_r, out_hour_nxt;
  minute_t       out_min_r, out_min_nxt;
  second_t       out_sec_r, out_sec_nxt;

  // shared subtract/compare unit
  logic [OpW-1:0] op_a, op_b;
  logic [OpW:0]   diff;
  logic           ge;
  logic           leap;
  logic           out_free;

  assign leap     = (year_r[1:0] == 2'd0);
  assign out_free = !out_valid_r || out_m.ready;

  // operand select per sequencer step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (st_r)
      ST_DIV_DAY: begin
        op_a = {rem_r, acc_r[SecsW-1]};
        op_b = OpW'(SecsPerDay);
      end
      ST_DIV_HOUR: begin
        op_a = {1'b0, rem_r};
        op_b = OpW'(SecsPerHour) << cnt_r[2:0];
      end
      ST_DIV_MIN: begin
        op_a = {1'b0, rem_r};
        op_b = OpW'(SecsPerMin) << cnt_r[2:0];
      end
      ST_YEAR: begin
        op_a = {2'b00, acc_r[15:0]};
        op_b = leap ? OpW'(DaysLeapYear) : OpW'(DaysCommonYear);
      end
      ST_MONTH: begin
        op_a = {2'b00, acc_r[15:0]};
        op_b = {13'd0, month_len(month_r, leap)};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = !diff[OpW];

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_hour_nxt  = out_hour_r;
    out_min_nxt   = out_min_r;
    out_sec_nxt   = out_sec_r;

    case (st_r)
      ST_IDLE: begin
        if (in_s.valid) begin
          acc_nxt   = in_s.epoch_seconds;
          rem_nxt   = '0;
          hour_nxt  = '0;
          min_nxt   = '0;
          year_nxt  = YearW'(FirstYear);
          month_nxt = 4'd1;
          cnt_nxt   = 5'd31;
          st_nxt    = ST_DIV_DAY;
        end
      end
      // restoring division by seconds per day, quotient shifts into acc
      ST_DIV_DAY: begin
        rem_nxt = ge ? diff[16:0] : op_a[16:0];
        acc_nxt = {acc_r[SecsW-2:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          cnt_nxt = 5'd4;
          st_nxt  = ST_DIV_HOUR;
        end
      end
      ST_DIV_HOUR: begin
        if (ge) begin
          rem_nxt = diff[16:0];
        end
        hour_nxt = {hour_r[HourW-2:0], ge};
        cnt_nxt  = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          cnt_nxt = 5'd5;
          st_nxt  = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (ge) begin
          rem_nxt = diff[16:0];
        end
        min_nxt = {min_r[MinuteW-2:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          st_nxt = ST_YEAR;
        end
      end
      // leave the year once the remaining days fit in it
      ST_YEAR: begin
        if (ge) begin
          acc_nxt[15:0] = diff[15:0];
          year_nxt      = year_r + YearW'(1);
        end else begin
          st_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ge && month_r != 4'd12) begin
          acc_nxt[15:0] = diff[15:0];
          month_nxt     = month_r + 4'd1;
        end else begin
          st_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = year_r;
          out_month_nxt = month_r;
          out_day_nxt   = acc_r[DayW-1:0] + DayW'(1);
          out_hour_nxt  = hour_r;
          out_min_nxt   = min_r;
          out_sec_nxt   = rem_r[SecondW-1:0];
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    hour_r      <= hour_nxt;
    min_r       <= min_nxt;
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_hour_r  <= out_hour_nxt;
    out_min_r   <= out_min_nxt;
    out_sec_r   <= out_sec_nxt;
  end

  assign in_s.ready   = (st_r == ST_IDLE);
  assign out_m.valid  = out_valid_r;
  assign out_m.year   = out_year_r;
  assign out_m.month  = out_month_r;
  assign out_m.day    = out_day_r;
  assign out_m.hour   = out_hour_r;
  assign out_m.minute = out_min_r;
  assign out_m.second = out_sec_r;

endmodule
`default_nettype wire
